>>> hw/rtl/hbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbt_pkg;

    localparam int NUM_VALUES      = 256;
    localparam int VALUE_BITS      = 8;
    localparam int RANK_COUNT_BITS = 32;
    localparam int TOP_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH     = 4;

    // One data word as it travels from the front to the back.
    typedef struct packed {
        logic [VALUE_BITS-1:0] data;
        logic                  last;
    } t_item;

    // Control that goes with each candidate the counter scan hands to the ranker.
    typedef struct packed {
        logic start;
        logic cand_valid;
        logic done;
    } t_scan_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/hbt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hbt_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [hbt_pkg::VALUE_BITS-1:0]   i_data_byte,
    input  wire                             i_end_of_set,
    output logic                            o_item_avail,
    output hbt_pkg::t_item                  o_item,
    input  wire                             i_pop
);

    localparam int PTR_W = $clog2(hbt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hbt_pkg::QUEUE_DEPTH + 1);

    hbt_pkg::t_item r_queue [hbt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_in_stall   = (r_count == CNT_W'(hbt_pkg::QUEUE_DEPTH));
    assign o_item_avail = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && o_item_avail;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= '{data: i_data_byte, last: i_end_of_set};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hbt_hist.sv
`timescale 1ns / 1ps
`default_nettype none

module hbt_hist #(
    parameter int COUNT_BITS = hbt_pkg::COUNT_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_item_avail,
    input  hbt_pkg::t_item                  i_item,
    output logic                            o_pop,
    input  wire                             i_rank_idle,
    output hbt_pkg::t_scan_ctl              o_ctl,
    output logic [hbt_pkg::VALUE_BITS-1:0]  o_cand_value,
    output logic [COUNT_BITS-1:0]           o_cand_count
);

    localparam int VB = hbt_pkg::VALUE_BITS;

    localparam logic [1:0] H_COUNT = 2'd0;
    localparam logic [1:0] H_WAIT  = 2'd1;
    localparam logic [1:0] H_SCAN  = 2'd2;
    localparam logic [1:0] H_CLEAR = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic [COUNT_BITS-1:0]         r_mem [hbt_pkg::NUM_VALUES];
    logic [hbt_pkg::NUM_VALUES-1:0] r_valid;

    logic [VB-1:0]         r_scan_addr;
    logic [VB-1:0]         rd_addr;
    logic                  scan_issue;
    logic                  start;

    logic                  r_s1_valid;
    logic                  r_s1_scan;
    logic [VB-1:0]         r_s1_addr;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    logic                  r_wr_valid;
    logic [VB-1:0]         r_wr_addr;
    logic [COUNT_BITS-1:0] r_wr_data;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic                  wr_en;

    assign o_pop      = (r_state == H_COUNT) && i_item_avail;
    assign scan_issue = (r_state == H_SCAN);
    assign start      = (r_state == H_WAIT) && i_rank_idle;
    assign rd_addr    = scan_issue ? r_scan_addr : i_item.data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_COUNT: begin
                if (o_pop && i_item.last) begin
                    n_state = H_WAIT;
                end
            end
            H_WAIT: begin
                if (i_rank_idle) begin
                    n_state = H_SCAN;
                end
            end
            H_SCAN: begin
                if (r_scan_addr == '1) begin
                    n_state = H_CLEAR;
                end
            end
            H_CLEAR: begin
                n_state = H_COUNT;
            end
            default: begin
                n_state = H_COUNT;
            end
        endcase
    end

    // The write of the previous word lands on the same edge that reads this one,
    // so that single write is forwarded; all older writes are in the memory.
    always_comb begin
        if (r_wr_valid && (r_wr_addr == r_s1_addr)) begin
            cur = r_wr_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
        inc   = (cur == '1) ? cur : cur + COUNT_BITS'(1);
        wr_en = r_s1_valid && !r_s1_scan;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[r_s1_addr] <= inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= rd_addr;
        r_s1_scan <= scan_issue;
        if (wr_en) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= H_COUNT;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_scan_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= o_pop || scan_issue;
            r_rd_vld   <= r_valid[rd_addr];
            if (start) begin
                r_scan_addr <= '0;
            end else if (scan_issue) begin
                r_scan_addr <= r_scan_addr + VB'(1);
            end
            if (r_state == H_CLEAR) begin
                r_valid    <= '0;
                r_wr_valid <= 1'b0;
            end else if (wr_en) begin
                r_valid[r_s1_addr] <= 1'b1;
                r_wr_valid         <= 1'b1;
            end
        end
    end

    assign o_ctl.start      = start;
    assign o_ctl.cand_valid = r_s1_valid && r_s1_scan;
    assign o_ctl.done       = r_s1_valid && r_s1_scan && (r_s1_addr == '1);
    assign o_cand_value     = r_s1_addr;
    assign o_cand_count     = cur;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_CLEAR) |=> (r_valid == '0) && !r_wr_valid)
        else $error("histogram not cleared after the scan");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_SCAN) |=> !(r_s1_valid && !r_s1_scan))
        else $error("count write behind a scan read");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |-> (r_state == H_CLEAR))
        else $error("scan finished out of step with the clear");

endmodule

`default_nettype wire

>>> hw/rtl/hbt_rank.sv
`timescale 1ns / 1ps
`default_nettype none

module hbt_rank #(
    parameter int TOP_ENTRIES = hbt_pkg::TOP_ENTRIES_DEF,
    parameter int COUNT_BITS  = hbt_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  hbt_pkg::t_scan_ctl                   i_ctl,
    input  wire [hbt_pkg::VALUE_BITS-1:0]        i_cand_value,
    input  wire [COUNT_BITS-1:0]                 i_cand_count,
    output logic                                 o_idle,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [hbt_pkg::VALUE_BITS-1:0]       o_rank_value,
    output logic [hbt_pkg::RANK_COUNT_BITS-1:0]  o_rank_count,
    output logic                                 o_rank_last
);

    localparam int VB    = hbt_pkg::VALUE_BITS;
    localparam int IDX_W = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_SCAN = 2'd1;
    localparam logic [1:0] R_OUT  = 2'd2;

    logic [1:0]            r_state;
    logic [IDX_W-1:0]      r_idx;
    logic [VB-1:0]         r_val [TOP_ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt [TOP_ENTRIES];
    logic [VB-1:0]         n_val [TOP_ENTRIES];
    logic [COUNT_BITS-1:0] n_cnt [TOP_ENTRIES];
    logic [TOP_ENTRIES-1:0] gt;
    logic [TOP_ENTRIES-1:0] gt_prev;
    logic                  out_take;
    logic                  sorted_ok;

    assign o_idle      = (r_state == R_IDLE);
    assign o_out_valid = (r_state == R_OUT);
    assign out_take    = o_out_valid && !i_out_stall;

    // The list stays in descending count order. A candidate goes in front of
    // the first entry it strictly beats, so on a tie the earlier (lower) value
    // keeps its place.
    always_comb begin
        for (int j = 0; j < TOP_ENTRIES; j++) begin
            gt[j] = i_cand_count > r_cnt[j];
        end
        gt_prev = gt << 1;
        for (int j = 0; j < TOP_ENTRIES; j++) begin
            n_val[j] = r_val[j];
            n_cnt[j] = r_cnt[j];
            if (i_ctl.start) begin
                n_val[j] = '0;
                n_cnt[j] = '0;
            end else if (i_ctl.cand_valid) begin
                if (gt[j] && !gt_prev[j]) begin
                    n_val[j] = i_cand_value;
                    n_cnt[j] = i_cand_count;
                end else if (gt[j]) begin
                    n_val[j] = r_val[(j > 0) ? j - 1 : 0];
                    n_cnt[j] = r_cnt[(j > 0) ? j - 1 : 0];
                end
            end else if (out_take) begin
                if (j < TOP_ENTRIES - 1) begin
                    n_val[j] = r_val[(j < TOP_ENTRIES - 1) ? j + 1 : j];
                    n_cnt[j] = r_cnt[(j < TOP_ENTRIES - 1) ? j + 1 : j];
                end else begin
                    n_val[j] = '0;
                    n_cnt[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TOP_ENTRIES; j++) begin
            r_val[j] <= n_val[j];
            r_cnt[j] <= n_cnt[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                R_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= R_SCAN;
                    end
                end
                R_SCAN: begin
                    if (i_ctl.done) begin
                        r_state <= R_OUT;
                        r_idx   <= '0;
                    end
                end
                R_OUT: begin
                    if (out_take) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (r_idx == IDX_W'(TOP_ENTRIES - 1)) begin
                            r_state <= R_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    assign o_rank_value = r_val[0];
    assign o_rank_last  = (r_idx == IDX_W'(TOP_ENTRIES - 1));

    if (COUNT_BITS > hbt_pkg::RANK_COUNT_BITS) begin : g_sat
        assign o_rank_count = (|r_cnt[0][COUNT_BITS-1:hbt_pkg::RANK_COUNT_BITS]) ?
                              '1 : r_cnt[0][hbt_pkg::RANK_COUNT_BITS-1:0];
    end else begin : g_ext
        assign o_rank_count = hbt_pkg::RANK_COUNT_BITS'(r_cnt[0]);
    end

    always_comb begin
        sorted_ok = 1'b1;
        for (int j = 0; j < TOP_ENTRIES - 1; j++) begin
            if (r_cnt[j] < r_cnt[(j < TOP_ENTRIES - 1) ? j + 1 : j]) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != R_IDLE) |-> sorted_ok)
        else $error("ranking list out of order");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == R_IDLE))
        else $error("scan started while a ranking is still out");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_rank_last) |=> (r_state == R_IDLE))
        else $error("ranking did not end after its final word");

endmodule

`default_nettype wire

>>> hw/rtl/byte_histogram_top16_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte histogram with top-k ranking. Data words enter through a four-entry
// queue; the counter memory (256 counters, cleared by per-entry valid bits)
// takes one word per cycle while counting, with a read-modify-write that
// forwards the previous write, so a word accepted into an empty queue passes
// through its queue entry and the read register before reaching its counter.
// A word flagged end_of_set closes the set: one scan of all 256 counters
// (one counter read per cycle) builds the sorted top list, and
// then TOP_ENTRIES words come out, highest count first, lower byte value
// first on equal counts, empty slots as value 0 with count 0. Counting of
// the next set runs while the ranking is still being delivered; its scan
// starts only after the last ranked word has been taken.
module byte_histogram_top16_core #(
    parameter int TOP_ENTRIES = hbt_pkg::TOP_ENTRIES_DEF,
    parameter int COUNT_BITS  = hbt_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire [hbt_pkg::VALUE_BITS-1:0]        i_data_byte,
    input  wire                                  i_end_of_set,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [hbt_pkg::VALUE_BITS-1:0]       o_rank_value,
    output logic [hbt_pkg::RANK_COUNT_BITS-1:0]  o_rank_count,
    output logic                                 o_rank_last
);

    logic                                item_avail;
    hbt_pkg::t_item                      item;
    logic                                pop;
    logic                                rank_idle;
    hbt_pkg::t_scan_ctl                  ctl;
    logic [hbt_pkg::VALUE_BITS-1:0]      cand_value;
    logic [COUNT_BITS-1:0]               cand_count;

    hbt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_end_of_set (i_end_of_set),
        .o_item_avail (item_avail),
        .o_item       (item),
        .i_pop        (pop)
    );

    hbt_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_avail (item_avail),
        .i_item       (item),
        .o_pop        (pop),
        .i_rank_idle  (rank_idle),
        .o_ctl        (ctl),
        .o_cand_value (cand_value),
        .o_cand_count (cand_count)
    );

    hbt_rank #(
        .TOP_ENTRIES (TOP_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_rank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cand_value (cand_value),
        .i_cand_count (cand_count),
        .o_idle       (rank_idle),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_rank_value (o_rank_value),
        .o_rank_count (o_rank_count),
        .o_rank_last  (o_rank_last)
    );

endmodule

`default_nettype wire
